FILE: sv/pca_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pca_pkg
// Shared types, constants and helper functions of the counter allocator.
// ============================================================================
package pca_pkg;

    localparam int NUM_COUNTERS = 8;
    localparam int CNT_W        = 3;
    localparam int COUNT_W      = 4;
    localparam int NUM_EVENTS   = 7;
    localparam int EVENT_W      = 3;
    localparam int SUPP_W       = 7;
    localparam int VERSION_W    = 8;
    localparam int OWNER_W      = 32;
    localparam int WORD_W       = 32;
    localparam int OVF_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_FREE     = 2'd1,
        REQ_START    = 2'd2,
        REQ_OVERFLOW = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_UNSUPPORTED  = 2'd1,
        ST_NONE_FREE    = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 2'd2;

    localparam logic [WORD_W-1:0] SEL_ENABLE = 32'h0040_0000;
    localparam logic [WORD_W-1:0] SEL_INTR   = 32'h0010_0000;
    localparam logic [WORD_W-1:0] SEL_USER   = 32'h0001_0000;
    localparam logic [WORD_W-1:0] SEL_KERNEL = 32'h0002_0000;

    localparam logic [VERSION_W-1:0] INTR_MIN_VERSION = 8'd2;

    // Classified request, as it travels from front to back.
    typedef struct packed {
        req_t                    req;
        logic                    ev_ok;
        logic [CNT_W-1:0]        sel;
        logic [OWNER_W-1:0]      owner;
        logic [WORD_W-1:0]       word;
        logic [NUM_COUNTERS-1:0] pending;
    } pca_cmd_t;

    // Counters present; a count above NUM_COUNTERS saturates.
    function automatic logic [NUM_COUNTERS-1:0] low_mask(input logic [COUNT_W-1:0] n);
        logic [NUM_COUNTERS:0] t;
        t = ({{NUM_COUNTERS{1'b0}}, 1'b1} << n) - 1'b1;
        if (n >= COUNT_W'(NUM_COUNTERS))
            return '1;
        return t[NUM_COUNTERS-1:0];
    endfunction

    // Raw event to hardware support bit (bits 1 and 2 swapped).
    function automatic logic [SUPP_W-1:0] ev_hw_bit(input logic [EVENT_W-1:0] ev);
        case (ev)
            3'd0:    return 7'h01;
            3'd1:    return 7'h04;
            3'd2:    return 7'h02;
            3'd3:    return 7'h08;
            3'd4:    return 7'h10;
            3'd5:    return 7'h20;
            3'd6:    return 7'h40;
            default: return 7'h00;
        endcase
    endfunction

    function automatic logic [7:0] ev_select(input logic [EVENT_W-1:0] ev);
        case (ev)
            3'd0:    return 8'h3c;
            3'd1:    return 8'h3c;
            3'd2:    return 8'hc0;
            3'd3:    return 8'h2e;
            3'd4:    return 8'h2e;
            3'd5:    return 8'hc4;
            3'd6:    return 8'hc5;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ev_umask(input logic [EVENT_W-1:0] ev);
        case (ev)
            3'd1:    return 8'h01;
            3'd3:    return 8'h4f;
            3'd4:    return 8'h41;
            default: return 8'h00;
        endcase
    endfunction

    // Index of the lowest set bit, 0 when none is set.
    function automatic logic [CNT_W-1:0] lowest_set(input logic [NUM_COUNTERS-1:0] v);
        logic [CNT_W-1:0] idx;
        idx = '0;
        for (int i = NUM_COUNTERS - 1; i >= 0; i--) begin
            if (v[i])
                idx = CNT_W'(i);
        end
        return idx;
    endfunction

endpackage

FILE: sv/pca_front.sv
`timescale 1ns / 1ps
// ============================================================================
// pca_front
// Takes request words, checks events and builds the select word and the
// overflow bits to scan.
// ============================================================================
module pca_front
    import pca_pkg::*;
(
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic [EVENT_W-1:0]      raw_event,
    input  logic [OWNER_W-1:0]      owner_index,
    input  logic [CNT_W-1:0]        counter_sel,
    input  logic [OVF_W-1:0]        overflow_bits,
    input  logic [SUPP_W-1:0]       supported_events,
    input  logic [COUNT_W-1:0]      counter_count,
    input  logic [VERSION_W-1:0]    unit_version,
    input  logic                    q_full,
    output logic                    q_push,
    output pca_cmd_t                q_cmd
);

    logic ev_valid;

    assign ev_valid = (raw_event < EVENT_W'(NUM_EVENTS));
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd         = '0;
        q_cmd.req     = req_t'(req_type);
        q_cmd.sel     = counter_sel;
        q_cmd.owner   = owner_index;
        case (req_t'(req_type))
            REQ_ALLOC:
            begin
                q_cmd.ev_ok = ev_valid && ((supported_events & ev_hw_bit(raw_event)) != '0);
            end
            REQ_START:
            begin
                q_cmd.ev_ok = ev_valid;
                if (ev_valid) begin
                    q_cmd.word = SEL_ENABLE | SEL_KERNEL | SEL_USER
                               | {16'h0, ev_umask(raw_event), ev_select(raw_event)};
                    if (unit_version >= INTR_MIN_VERSION)
                        q_cmd.word = q_cmd.word | SEL_INTR;
                end
            end
            REQ_OVERFLOW:
            begin
                q_cmd.pending = overflow_bits[NUM_COUNTERS-1:0] & low_mask(counter_count);
            end
            default:
            begin
                q_cmd.ev_ok = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/pca_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// pca_queue
// Two-entry queue of classified requests between front and back.
// ============================================================================
module pca_queue
    import pca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pca_cmd_t push_cmd,
    input  logic     pop,
    output pca_cmd_t head_cmd,
    output logic     full,
    output logic     empty
);

    pca_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: sv/pca_back.sv
`timescale 1ns / 1ps
// ============================================================================
// pca_back
// Carries out requests against the free map and owner table, scans overflow
// bits one per cycle unless the output stalls; holds the result register.
// ============================================================================
module pca_back
    import pca_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pca_cmd_t                head_cmd,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  logic [COUNT_W-1:0]      counter_count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status_code,
    output logic [CNT_W-1:0]        counter_id,
    output logic [OWNER_W-1:0]      owner_tag,
    output logic [WORD_W-1:0]       event_select_word,
    output logic                    last_result
);

    logic [NUM_COUNTERS-1:0] free_map_reg;
    logic [NUM_COUNTERS-1:0] free_map_next;
    logic [OWNER_W-1:0]      owner_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] owner_valid_reg;
    logic [NUM_COUNTERS-1:0] owner_valid_next;
    logic                    scan_active_reg;
    logic                    scan_active_next;
    logic [NUM_COUNTERS-1:0] scan_pend_reg;
    logic [NUM_COUNTERS-1:0] scan_pend_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic [CNT_W-1:0]        id_reg;
    logic [CNT_W-1:0]        id_next;
    logic [OWNER_W-1:0]      owner_reg;
    logic [OWNER_W-1:0]      owner_next;
    logic [WORD_W-1:0]       word_reg;
    logic [WORD_W-1:0]       word_next;
    logic                    last_reg;
    logic                    last_next;

    logic                    cap;
    logic                    emit;
    logic                    own_we;
    logic [NUM_COUNTERS-1:0] pend_src;
    logic [NUM_COUNTERS-1:0] pend_rest;
    logic [CNT_W-1:0]        pick;
    logic [OWNER_W-1:0]      pick_owner;
    logic [NUM_COUNTERS-1:0] avail;
    logic [CNT_W-1:0]        alloc_id;

    // Result register is free, or its word leaves this cycle.
    assign cap        = !out_valid_reg || out_ready;
    assign pend_src   = scan_active_reg ? scan_pend_reg : head_cmd.pending;
    assign pick       = lowest_set(pend_src);
    assign pend_rest  = pend_src & (pend_src - 1'b1);
    assign pick_owner = owner_valid_reg[pick] ? owner_mem[pick] : '0;
    assign avail      = free_map_reg & low_mask(counter_count);
    assign alloc_id   = lowest_set(avail);

    always_comb
    begin
        free_map_next    = free_map_reg;
        owner_valid_next = owner_valid_reg;
        scan_active_next = scan_active_reg;
        scan_pend_next   = scan_pend_reg;
        status_next      = status_reg;
        id_next          = id_reg;
        owner_next       = owner_reg;
        word_next        = word_reg;
        last_next        = last_reg;
        emit             = 1'b0;
        q_pop            = 1'b0;
        own_we           = 1'b0;

        if (cap && scan_active_reg) begin
            emit             = 1'b1;
            status_next      = ST_OK;
            id_next          = pick;
            owner_next       = pick_owner;
            word_next        = '0;
            last_next        = (pend_rest == '0);
            scan_pend_next   = pend_rest;
            scan_active_next = (pend_rest != '0);
        end else if (cap && !q_empty) begin
            q_pop      = 1'b1;
            owner_next = '0;
            word_next  = '0;
            last_next  = 1'b1;
            case (head_cmd.req)
                REQ_ALLOC:
                begin
                    emit    = 1'b1;
                    id_next = '0;
                    if (!head_cmd.ev_ok) begin
                        status_next = ST_UNSUPPORTED;
                    end else if (avail == '0) begin
                        status_next = ST_NONE_FREE;
                    end else begin
                        status_next                = ST_OK;
                        id_next                    = alloc_id;
                        free_map_next[alloc_id]    = 1'b0;
                        owner_valid_next[alloc_id] = 1'b1;
                        own_we                     = 1'b1;
                    end
                end
                REQ_FREE:
                begin
                    emit    = 1'b1;
                    id_next = head_cmd.sel;
                    if (free_map_reg[head_cmd.sel]) begin
                        status_next = ST_ALREADY_FREE;
                    end else begin
                        status_next                 = ST_OK;
                        free_map_next[head_cmd.sel] = 1'b1;
                    end
                end
                REQ_START:
                begin
                    emit        = 1'b1;
                    id_next     = head_cmd.sel;
                    status_next = head_cmd.ev_ok ? ST_OK : ST_UNSUPPORTED;
                    word_next   = head_cmd.word;
                end
                REQ_OVERFLOW:
                begin
                    if (pend_src != '0) begin
                        emit             = 1'b1;
                        status_next      = ST_OK;
                        id_next          = pick;
                        owner_next       = pick_owner;
                        last_next        = (pend_rest == '0);
                        scan_pend_next   = pend_rest;
                        scan_active_next = (pend_rest != '0);
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (cap)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            free_map_reg    <= '1;
            owner_valid_reg <= '0;
            scan_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            free_map_reg    <= free_map_next;
            owner_valid_reg <= owner_valid_next;
            scan_active_reg <= scan_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pend_reg <= scan_pend_next;
        status_reg    <= status_next;
        id_reg        <= id_next;
        owner_reg     <= owner_next;
        word_reg      <= word_next;
        last_reg      <= last_next;
        if (own_we)
            owner_mem[alloc_id] <= head_cmd.owner;
    end

    assign out_valid         = out_valid_reg;
    assign status_code       = status_reg;
    assign counter_id        = id_reg;
    assign owner_tag         = owner_reg;
    assign event_select_word = word_reg;
    assign last_result       = last_reg;

endmodule

FILE: sv/perf_counter_allocator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// perf_counter_allocator_core
// Performance counter allocator: free bitmap, owner table, event-select
// composition and overflow reporting for eight general counters.
// ============================================================================
//
//  channel   handshake              payload
//  -------   --------------------   -------------------------------------------
//  in        in_valid / in_ready    req_type, raw_event, owner_index,
//                                   counter_sel, overflow_bits
//  out       out_valid / out_ready  status_code, counter_id, owner_tag,
//                                   event_select_word, last_result
//  cfg       cfg_write              cfg_index, cfg_data (no back-pressure)
//
//  A request word is taken into a two-entry queue on the edge it is accepted;
//  the back end pops it when the output register can take a word, and its
//  first result word enters that register on the pop. Allocate, free and
//  start give one result word; overflow gives one word per set overflow bit
//  of a present counter, lowest first, one per cycle unless the output stalls.
//  With no output stall, single-result requests sustain one per cycle.
//  Reset (rst_n low, asynchronous) marks all counters free, clears the owner
//  valid bits and the config registers; no clearing pass is needed.
//  A stalled output holds the back end; the queue then fills and in_ready
//  drops, so the stall reaches the input.
//
module perf_counter_allocator_core
    import pca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    input  logic [EVENT_W-1:0]     raw_event,
    input  logic [OWNER_W-1:0]     owner_index,
    input  logic [CNT_W-1:0]       counter_sel,
    input  logic [OVF_W-1:0]       overflow_bits,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status_code,
    output logic [CNT_W-1:0]       counter_id,
    output logic [OWNER_W-1:0]     owner_tag,
    output logic [WORD_W-1:0]      event_select_word,
    output logic                   last_result
);

    // Configuration registers; the user writes only while idle (unenforced).
    logic [SUPP_W-1:0]    supported_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [VERSION_W-1:0] version_reg;

    // Front to queue, queue to back.
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    pca_cmd_t push_cmd;
    pca_cmd_t head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            supported_reg <= '0;
            count_reg     <= '0;
            version_reg   <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_SUPPORTED: supported_reg <= cfg_data[SUPP_W-1:0];
                CFG_COUNT:     count_reg     <= cfg_data[COUNT_W-1:0];
                CFG_VERSION:   version_reg   <= cfg_data[VERSION_W-1:0];
                default:       version_reg   <= version_reg;
            endcase
        end
    end

    // Front: checks the event, composes the select word, masks overflow bits
    // down to the counters present.
    pca_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .raw_event        (raw_event),
        .owner_index      (owner_index),
        .counter_sel      (counter_sel),
        .overflow_bits    (overflow_bits),
        .supported_events (supported_reg),
        .counter_count    (count_reg),
        .unit_version     (version_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    pca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: owns the free map and owner table, drives the result register.
    pca_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_cmd          (head_cmd),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .counter_count     (count_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status_code       (status_code),
        .counter_id        (counter_id),
        .owner_tag         (owner_tag),
        .event_select_word (event_select_word),
        .last_result       (last_result)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the performance counter allocator. Drives request
// words through the valid/ready input, keeps its own copy of the free bitmap,
// owner tags and config registers, and checks every result word against it.
// ============================================================================
module tb;
    import pca_pkg::*;

    localparam int IDLE_PCT     = 14;    // chance of an idle cycle, per side
    localparam int DRAIN_CYCLES = 8;     // settling time after the last owed word
    localparam int STALL_LIMIT  = 2000;  // quiet cycles before the run is abandoned
    localparam int PHASE_ITEMS  = 92;    // five random phases, 460 request words

    // Index 3 is not a register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    // Raw event tables: support bit (1 and 2 swapped), event code, unit mask.
    localparam logic [SUPP_W-1:0] EV_SUPPORT_BIT [NUM_EVENTS] =
        '{7'h01, 7'h04, 7'h02, 7'h08, 7'h10, 7'h20, 7'h40};
    localparam logic [7:0] EV_CODE [NUM_EVENTS] =
        '{8'h3c, 8'h3c, 8'hc0, 8'h2e, 8'h2e, 8'hc4, 8'hc5};
    localparam logic [7:0] EV_UMASK [NUM_EVENTS] =
        '{8'h00, 8'h01, 8'h00, 8'h4f, 8'h41, 8'h00, 8'h00};

    typedef struct {
        req_t                req;
        logic [EVENT_W-1:0]  ev;
        logic [OWNER_W-1:0]  owner;
        logic [CNT_W-1:0]    sel;
        logic [OVF_W-1:0]    ovf;
    } req_word_t;

    typedef struct {
        status_t             status;
        logic [CNT_W-1:0]    id;
        logic [OWNER_W-1:0]  owner;
        logic [WORD_W-1:0]   word;
        logic                last;
    } result_word_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             req_type;
    logic [EVENT_W-1:0]     raw_event;
    logic [OWNER_W-1:0]     owner_index;
    logic [CNT_W-1:0]       counter_sel;
    logic [OVF_W-1:0]       overflow_bits;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             status_code;
    logic [CNT_W-1:0]       counter_id;
    logic [OWNER_W-1:0]     owner_tag;
    logic [WORD_W-1:0]      event_select_word;
    logic                   last_result;

    perf_counter_allocator_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .raw_event         (raw_event),
        .owner_index       (owner_index),
        .counter_sel       (counter_sel),
        .overflow_bits     (overflow_bits),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status_code       (status_code),
        .counter_id        (counter_id),
        .owner_tag         (owner_tag),
        .event_select_word (event_select_word),
        .last_result       (last_result)
    );

    // ------------------------------------------------------------------------
    // Predicted state: config registers, free bitmap, owner tags.
    // All of it matches the reset state of the block.
    // ------------------------------------------------------------------------
    logic [SUPP_W-1:0]       supp_mask   = '0;
    logic [COUNT_W-1:0]      count_reg   = '0;
    logic [VERSION_W-1:0]    version_reg = '0;
    logic [NUM_COUNTERS-1:0] free_bits   = '1;
    logic [OWNER_W-1:0]      owner_tags [NUM_COUNTERS] = '{default: '0};

    result_word_t owed_results [$];   // result words still to come, oldest first
    int           errors  = 0;
    bit           gaps_on = 1'b1;     // sender idles at random
    bit           stall_on = 1'b1;    // receiver stalls at random

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Counters present: count above NUM_COUNTERS saturates.
    function automatic logic [NUM_COUNTERS-1:0] present_mask(input logic [COUNT_W-1:0] n);
        logic [NUM_COUNTERS-1:0] m;
        for (int i = 0; i < NUM_COUNTERS; i++)
            m[i] = (i < n);
        return m;
    endfunction

    function automatic bit event_supported(input logic [EVENT_W-1:0] ev);
        if (ev >= EVENT_W'(NUM_EVENTS))
            return 1'b0;
        return (supp_mask & EV_SUPPORT_BIT[ev]) != '0;
    endfunction

    // Works out the result words of one accepted request and updates the
    // predicted bitmap and owner tags.
    task automatic update_counters(input req_word_t w);
        result_word_t            r;
        logic [NUM_COUNTERS-1:0] avail;
        logic [NUM_COUNTERS-1:0] pend;
        bit                      found;
        r = '{status: ST_OK, id: w.sel, owner: '0, word: '0, last: 1'b1};
        case (w.req)
            REQ_ALLOC:
            begin
                r.id  = '0;
                avail = free_bits & present_mask(count_reg);
                found = 1'b0;
                if (!event_supported(w.ev))
                    r.status = ST_UNSUPPORTED;
                else if (avail == '0)
                    r.status = ST_NONE_FREE;
                else
                begin
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        if (avail[i] && !found)
                        begin
                            found = 1'b1;
                            r.id  = CNT_W'(i);
                        end
                    end
                    owner_tags[r.id] = w.owner;
                    free_bits[r.id]  = 1'b0;
                end
                owed_results.push_back(r);
            end
            REQ_FREE:
            begin
                if (free_bits[w.sel])
                    r.status = ST_ALREADY_FREE;
                else
                    free_bits[w.sel] = 1'b1;
                owed_results.push_back(r);
            end
            REQ_START:
            begin
                if (w.ev >= EVENT_W'(NUM_EVENTS))
                    r.status = ST_UNSUPPORTED;
                else
                begin
                    r.word = SEL_ENABLE | SEL_KERNEL | SEL_USER
                           | {16'h0, EV_UMASK[w.ev], EV_CODE[w.ev]};
                    if (version_reg >= INTR_MIN_VERSION)
                        r.word |= SEL_INTR;
                end
                owed_results.push_back(r);
            end
            default:
            begin
                // overflow: one word per set bit of a present counter
                pend = w.ovf[NUM_COUNTERS-1:0] & present_mask(count_reg);
                for (int i = 0; i < NUM_COUNTERS; i++)
                begin
                    if (pend[i])
                    begin
                        r.id    = CNT_W'(i);
                        r.owner = owner_tags[i];
                        r.last  = (pend >> (i + 1)) == '0;
                        owed_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    function automatic req_word_t req_word(input req_t req, input logic [EVENT_W-1:0] ev,
                                           input logic [OWNER_W-1:0] owner,
                                           input logic [CNT_W-1:0] sel,
                                           input logic [OVF_W-1:0] ovf);
        req_word_t w;
        w = '{req: req, ev: ev, owner: owner, sel: sel, ovf: ovf};
        return w;
    endfunction

    // Mostly well-formed traffic: frees aim at allocated counters, overflow
    // words often flag exactly the owned ones; the rest is noise.
    function automatic req_word_t random_req();
        req_word_t               w;
        int                      pick;
        logic [NUM_COUNTERS-1:0] used;
        used    = ~free_bits;
        w.ev    = ($urandom_range(0, 15) == 0) ? 3'd7 : EVENT_W'($urandom_range(0, 6));
        w.owner = $urandom;
        w.sel   = CNT_W'($urandom_range(0, 7));
        w.ovf   = {$urandom, $urandom};
        pick    = $urandom_range(0, 99);
        if (pick < 35)
            w.req = REQ_ALLOC;
        else if (pick < 65)
        begin
            w.req = REQ_FREE;
            if (used != '0 && $urandom_range(0, 4) != 0)
            begin
                do
                    w.sel = CNT_W'($urandom_range(0, 7));
                while (!used[w.sel]);
            end
        end
        else if (pick < 80)
            w.req = REQ_START;
        else
        begin
            w.req = REQ_OVERFLOW;
            case ($urandom_range(0, 7))
                0:       w.ovf = '0;
                1:       w.ovf = '1;
                2, 3:    w.ovf[NUM_COUNTERS-1:0] = used;
                default: ;
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Valid is left high after acceptance; the next call either
    // drives a fresh word or drops valid at the very next falling edge.
    // ------------------------------------------------------------------------
    task automatic send_req(input req_word_t w);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= w.req;
        raw_event     <= w.ev;
        owner_index   <= w.owner;
        counter_sel   <= w.sel;
        overflow_bits <= w.ovf;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        update_counters(w);
    endtask

    // Drop valid, wait for every owed word, then let the back end settle
    // (an overflow word with no present bit leaves nothing to wait for).
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SUPPORTED: supp_mask   = data[SUPP_W-1:0];
            CFG_COUNT:     count_reg   = data[COUNT_W-1:0];
            CFG_VERSION:   version_reg = data[VERSION_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] supp, input logic [7:0] cnt, input logic [7:0] ver);
        wait_drained();
        write_reg(CFG_SUPPORTED, supp);
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_VERSION, ver);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls driven at the falling edge, words checked at
    // the rising edge against the oldest owed word.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= !(stall_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: result word with none owed, expected none, actual id %0d",
                         $time, counter_id);
                errors++;
            end
            else
            begin
                e = owed_results.pop_front();
                check_field("status_code", 32'(e.status), 32'(status_code));
                check_field("counter_id", 32'(e.id), 32'(counter_id));
                check_field("owner_tag", e.owner, owner_tag);
                check_field("event_select_word", e.word, event_select_word);
                check_field("last_result", 32'(e.last), 32'(last_result));
            end
        end
    end

    // Abandon the run once neither channel has moved for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Config still at reset: nothing supported, no counters present, version 0.
    task automatic test_reset_defaults();
        send_req(req_word(REQ_ALLOC, 3'd0, 32'h1234_5678, 3'd0, '0));
        send_req(req_word(REQ_FREE, 3'd0, '0, 3'd7, '0));
        send_req(req_word(REQ_START, 3'd6, '0, 3'd5, '0));
        send_req(req_word(REQ_OVERFLOW, 3'd0, '0, 3'd0, '1));   // no counter present
        wait_drained();
        write_reg(CFG_NONE, 8'hff);
    endtask

    // Fill all eight counters lowest first, then one more finds none free.
    task automatic test_allocate();
        logic [OWNER_W-1:0] tags [NUM_COUNTERS] =
            '{32'h0, 32'hffff_ffff, 32'ha5a5_a5a5, 32'h5a5a_5a5a,
              32'h0000_0001, 32'h8000_0000, 32'hdead_beef, 32'h7fff_fffe};
        for (int i = 0; i < NUM_COUNTERS; i++)
            send_req(req_word(REQ_ALLOC, EVENT_W'(i % NUM_EVENTS), tags[i], 3'd0, '0));
        send_req(req_word(REQ_ALLOC, 3'd2, 32'hcafe_f00d, 3'd0, '0));
    endtask

    // Start ignores allocation; raw event 7 is out of range.
    task automatic test_start();
        send_req(req_word(REQ_START, 3'd1, '0, 3'd0, '0));
        send_req(req_word(REQ_START, 3'd3, '0, 3'd7, '0));
        send_req(req_word(REQ_START, 3'd4, '0, 3'd2, '0));
        send_req(req_word(REQ_START, 3'd7, '0, 3'd3, '0));
    endtask

    // All bits set, only bits above the counters, and the top counter alone.
    task automatic test_overflow();
        send_req(req_word(REQ_OVERFLOW, 3'd0, '0, 3'd0, '1));
        send_req(req_word(REQ_OVERFLOW, 3'd0, '0, 3'd0, {{56{1'b1}}, 8'h00}));
        send_req(req_word(REQ_OVERFLOW, 3'd0, '0, 3'd0, 64'h80));
    endtask

    // Free, double free, reuse of the freed slot.
    task automatic test_free();
        send_req(req_word(REQ_FREE, 3'd0, '0, 3'd3, '0));
        send_req(req_word(REQ_FREE, 3'd0, '0, 3'd3, '0));
        send_req(req_word(REQ_ALLOC, 3'd5, 32'h0bad_f00d, 3'd0, '0));
        send_req(req_word(REQ_FREE, 3'd0, '0, 3'd0, '0));
    endtask

    // Random phases over several settings. The first runs with no idling on
    // either side; the third pauses halfway until every owed word is back.
    task automatic test_random();
        logic [7:0] phase_cfg [5][3] =
            '{'{8'h7f, 8'h08, 8'hff},
              '{8'h00, 8'h03, 8'h01},
              '{8'hff, 8'h01, 8'h02},
              '{8'h00, 8'h00, 8'h00},
              '{8'h00, 8'hf7, 8'h00}};
        phase_cfg[1][0] = 8'($urandom);
        phase_cfg[3][0] = 8'($urandom);
        phase_cfg[3][1] = 8'($urandom);
        phase_cfg[3][2] = 8'($urandom);
        phase_cfg[4][0] = 8'($urandom);
        for (int p = 0; p < 5; p++)
        begin
            set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            gaps_on  = (p != 0);
            stall_on = (p != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_req(random_req());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_SUPPORTED;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = REQ_ALLOC;
        raw_event     = '0;
        owner_index   = '0;
        counter_sel   = '0;
        overflow_bits = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        set_config(8'hff, 8'h0f, 8'h02);   // count 15 saturates to eight
        test_allocate();
        test_start();
        test_overflow();
        test_free();
        test_random();

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
